// File: hw/rtl/keyframe_vector_sampler_macros.svh
// ----------------------------------------------------------------------------
// Keyframe vector sampler assertion macros
// Shorthand for clocked checks, disabled while the synchronous reset is high.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VECTOR_SAMPLER_MACROS_SVH
`define KEYFRAME_VECTOR_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe_vector_sampler check failed");

// The consequent must hold in the cycle after the antecedent.
`define KVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe_vector_sampler check failed");

`endif

// File: hw/rtl/kvs_pkg.sv
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared widths, constants and the key record of the keyframe vector sampler.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int MAX_KEYS_DEF = 64;

  localparam int TIME_W = 24;   // Q16.8 unsigned
  localparam int VAL_W  = 32;   // Q16.16 signed
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;
  localparam int SEG_W  = 6;
  localparam int FACT_W = 17;   // Q0.16 plus one bit so that 1.0 fits

  localparam logic [FACT_W-1:0] FACT_ONE = 17'h10000;

  localparam int DIV_STEPS = 16;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]       time_v;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } key_t;

endpackage

// File: hw/rtl/kvs_ram.sv
// ----------------------------------------------------------------------------
// kvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/kvs_lerp.sv
// ----------------------------------------------------------------------------
// kvs_lerp
// Shared interpolation unit: registered delta times factor, then rounding to
// Q16.16, add of the start value and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module kvs_lerp (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [kvs_pkg::VAL_W-1:0]  start_val,
  input  logic signed [kvs_pkg::VAL_W-1:0]  end_val,
  input  logic [kvs_pkg::FACT_W-1:0]        factor,
  output logic signed [kvs_pkg::VAL_W-1:0]  result
);

  localparam int DW = kvs_pkg::VAL_W + 1;
  localparam int PW = DW + kvs_pkg::FACT_W + 1;
  localparam int RW = PW + 1 - 16;
  localparam int SW = RW + 1;

  logic signed [DW-1:0]             delta;
  logic signed [kvs_pkg::FACT_W:0]  fact_s;
  logic signed [PW-1:0]             prod;
  logic signed [PW-1:0]             prod_q;
  logic signed [kvs_pkg::VAL_W-1:0] start_q;
  logic signed [PW:0]               biased;
  logic signed [RW-1:0]             rounded;
  logic signed [SW-1:0]             sum;

  assign delta  = {end_val[kvs_pkg::VAL_W-1], end_val}
                - {start_val[kvs_pkg::VAL_W-1], start_val};
  assign fact_s = {1'b0, factor};
  assign prod   = delta * fact_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q  <= prod;
      start_q <= start_val;
    end
  end

  // Round half up, then floor by the arithmetic shift.
  assign biased  = {prod_q[PW-1], prod_q} + (PW+1)'(32768);
  assign rounded = biased[PW:16];
  assign sum     = {{(SW-kvs_pkg::VAL_W){start_q[kvs_pkg::VAL_W-1]}}, start_q}
                 + {rounded[RW-1], rounded};

  always_comb begin
    if (sum > SW'(signed'(33'sh0_7FFF_FFFF))) begin
      result = 32'sh7FFF_FFFF;
    end else if (sum < SW'(signed'(33'sh1_8000_0000))) begin
      result = 32'sh8000_0000;
    end else begin
      result = sum[kvs_pkg::VAL_W-1:0];
    end
  end

endmodule

// File: hw/rtl/keyframe_vector_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_vector_sampler
// Linear interpolation over a table of time-stamped three-component keys.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ---------------------------------------
//  command   start, busy               operation, key_slot, time_value,
//                                      value_x, value_y, value_z
//  result    done (one-cycle strobe)   out_x, out_y, out_z, segment_index,
//                                      past_end, zero_span
//  config    key_count_we              key_count
//
// A word is taken on a rising edge with start high and busy low. A key write
// goes straight into the key RAM in that same cycle and never raises busy.
// A sample with a single valid key reads that key and puts it out as its
// result word. Otherwise the linear scan of key times through the RAM read
// port stops at key n; then the two segment keys are fetched and the factor
// is formed, the 16-step restoring divider runs (only when the factor is a
// true fraction), the one shared multiplier serves each component in turn
// and the output register takes the result.
// Reset is synchronous and active high; it clears the sequencer and sets the
// key count to 1. The key table is not cleared. The receiver cannot stall:
// done is high for exactly one cycle per sample and the outputs hold after.
//
module keyframe_vector_sampler #(
  parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [kvs_pkg::SLOT_W-1:0]        key_slot,
  input  logic [kvs_pkg::TIME_W-1:0]        time_value,
  input  logic signed [kvs_pkg::VAL_W-1:0]  value_x,
  input  logic signed [kvs_pkg::VAL_W-1:0]  value_y,
  input  logic signed [kvs_pkg::VAL_W-1:0]  value_z,
  input  logic                              key_count_we,
  input  logic [kvs_pkg::CNT_W-1:0]         key_count,
  output logic                              done,
  output logic signed [kvs_pkg::VAL_W-1:0]  out_x,
  output logic signed [kvs_pkg::VAL_W-1:0]  out_y,
  output logic signed [kvs_pkg::VAL_W-1:0]  out_z,
  output logic [kvs_pkg::SEG_W-1:0]         segment_index,
  output logic                              past_end,
  output logic                              zero_span
);

  `include "keyframe_vector_sampler_macros.svh"

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int TW = kvs_pkg::TIME_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RD1  = 4'd3;
  localparam logic [3:0] S_CALC = 4'd4;
  localparam logic [3:0] S_FACT = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;

  logic [3:0]                       state;
  logic [kvs_pkg::CNT_W-1:0]        count_cfg;
  logic [CW-1:0]                    n_eff;
  logic [AW-1:0]                    last_idx;
  logic                             n_is_one;

  logic [TW-1:0]                    t_in;
  logic [AW-1:0]                    last;
  logic                             single;
  logic [AW-1:0]                    seg;
  logic [AW-1:0]                    nx;
  logic                             past;
  logic                             zero;
  logic [AW-1:0]                    scan_addr;
  logic [AW-1:0]                    rd_idx;
  logic                             rd_vld;

  kvs_pkg::key_t                    rd_key;
  kvs_pkg::key_t                    wr_key;
  kvs_pkg::key_t                    key0;
  kvs_pkg::key_t                    key1;
  logic                             ram_we;
  logic [AW-1:0]                    raddr;

  logic signed [TW:0]               span;
  logic signed [TW:0]               offset;
  logic [TW-1:0]                    div_rem;
  logic [TW-1:0]                    div_span;
  logic [TW:0]                      rem2;
  logic                             rem_ge;
  logic [$clog2(kvs_pkg::DIV_STEPS)-1:0] div_cnt;
  logic [kvs_pkg::FACT_W-1:0]       factor;

  logic [1:0]                       comp;
  logic signed [kvs_pkg::VAL_W-1:0] lerp_a;
  logic signed [kvs_pkg::VAL_W-1:0] lerp_b;
  logic signed [kvs_pkg::VAL_W-1:0] lerp_res;

  // Effective key count: zero reads as one, anything above the table size
  // saturates to the table size.
  always_comb begin
    if (count_cfg == '0) begin
      n_eff = CW'(1);
    end else if (32'(count_cfg) > MAX_KEYS) begin
      n_eff = CW'(MAX_KEYS);
    end else begin
      n_eff = CW'(count_cfg);
    end
  end

  assign n_is_one = (n_eff == CW'(1));
  assign last_idx = AW'(n_eff - CW'(1));
  assign busy     = (state != S_IDLE);
  assign nx       = seg + AW'(1);

  // Key writes land in the RAM on the accepting edge; slots past the table
  // are dropped.
  assign ram_we        = start && !busy && (operation == kvs_pkg::OP_WRITE)
                         && (32'(key_slot) < MAX_KEYS);
  assign wr_key.time_v = time_value;
  assign wr_key.x      = value_x;
  assign wr_key.y      = value_y;
  assign wr_key.z      = value_z;

  always_comb begin
    unique case (state)
      S_SCAN:  raddr = scan_addr;
      S_RD1:   raddr = nx;
      default: raddr = seg;
    endcase
  end

  kvs_ram #(
    .WIDTH ($bits(kvs_pkg::key_t)),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(key_slot)),
    .wdata (wr_key),
    .raddr (raddr),
    .rdata (rd_key)
  );

  // Factor set-up: both differences are signed, one bit wider than a time.
  assign span   = $signed({1'b0, key1.time_v}) - $signed({1'b0, key0.time_v});
  assign offset = $signed({1'b0, t_in}) - $signed({1'b0, key0.time_v});

  // One restoring division step per cycle; the remainder always stays below
  // the span.
  assign rem2   = {div_rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, div_span});

  always_comb begin
    case (comp)
      2'd0:    begin lerp_a = key0.x; lerp_b = key1.x; end
      2'd1:    begin lerp_a = key0.y; lerp_b = key1.y; end
      default: begin lerp_a = key0.z; lerp_b = key1.z; end
    endcase
  end

  kvs_lerp u_lerp (
    .clk       (clk),
    .en        (state == S_MUL),
    .start_val (lerp_a),
    .end_val   (lerp_b),
    .factor    (factor),
    .result    (lerp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      rd_vld    <= 1'b0;
      count_cfg <= kvs_pkg::CNT_W'(1);
    end else begin
      done   <= 1'b0;
      rd_vld <= 1'b0;
      if (key_count_we) begin
        count_cfg <= key_count;
      end
      unique case (state)
        S_IDLE: begin
          if (start && (operation == kvs_pkg::OP_SAMPLE)) begin
            t_in      <= time_value;
            seg       <= '0;
            past      <= 1'b0;
            zero      <= 1'b0;
            single    <= n_is_one;
            last      <= last_idx;
            scan_addr <= AW'(1);
            state     <= n_is_one ? S_RD0 : S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued back to back; each compare sees the key time
          // fetched in the previous cycle.
          rd_vld <= 1'b1;
          rd_idx <= scan_addr;
          if (scan_addr != last) begin
            scan_addr <= scan_addr + AW'(1);
          end
          if (rd_vld) begin
            if (t_in < rd_key.time_v) begin
              seg    <= rd_idx - AW'(1);
              rd_vld <= 1'b0;
              state  <= S_RD0;
            end else if (rd_idx == last) begin
              seg    <= '0;
              past   <= 1'b1;
              rd_vld <= 1'b0;
              state  <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          key0 <= rd_key;
          if (single) begin
            out_x         <= rd_key.x;
            out_y         <= rd_key.y;
            out_z         <= rd_key.z;
            segment_index <= '0;
            past_end      <= 1'b0;
            zero_span     <= 1'b0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          key1  <= rd_key;
          state <= S_FACT;
        end
        S_FACT: begin
          zero     <= (span == '0);
          div_rem  <= offset[TW-1:0];
          div_span <= span[TW-1:0];
          div_cnt  <= '0;
          comp     <= 2'd0;
          if (span[TW] || (span == '0) || offset[TW] || (offset == '0)) begin
            // Zero or negative span, or a time at or before the start key.
            factor <= '0;
            state  <= S_MUL;
          end else if (offset >= span) begin
            factor <= kvs_pkg::FACT_ONE;
            state  <= S_MUL;
          end else begin
            factor <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            div_rem <= TW'(rem2 - {1'b0, div_span});
          end else begin
            div_rem <= rem2[TW-1:0];
          end
          factor  <= {factor[kvs_pkg::FACT_W-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == ($bits(div_cnt))'(kvs_pkg::DIV_STEPS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          case (comp)
            2'd0:    out_x <= lerp_res;
            2'd1:    out_y <= lerp_res;
            default: out_z <= lerp_res;
          endcase
          if (comp == 2'd2) begin
            segment_index <= kvs_pkg::SEG_W'(seg);
            past_end      <= past;
            zero_span     <= zero;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A sample that is taken keeps the block busy on the next cycle.
  `KVS_ASSERT_NEXT(a_sample_busy, start && !busy && (operation == kvs_pkg::OP_SAMPLE), busy)
  // A result is only ever announced as the sequencer returns to idle.
  `KVS_ASSERT_SAME(a_done_idle, done, !busy && $past(busy))
  // The scan never runs when the table holds a single key.
  `KVS_ASSERT_SAME(a_scan_multi, state == S_SCAN, !single)

endmodule
